### hdl/uscal_pkg.sv
`default_nettype none

package uscal_pkg;

  localparam int SecsW   = 41;
  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;

  // Valid span: 0001-01-01 00:00:00 .. 9999-12-31 23:59:59
  localparam logic signed [SecsW-1:0] SecsMin    = -41'sd62135596800;
  localparam logic signed [SecsW-1:0] SecsMax    = 41'sd253402300799;
  localparam logic signed [SecsW-1:0] SecsOffset = 41'sd62135596800;

  // Day 0 of the March-based count is 0000-03-01
  localparam int MarchOffset = 306;

  localparam int DaysPer400Y = 146097;
  localparam int DaysPer100Y = 36524;
  localparam int DaysPer4Y   = 1461;
  localparam int DaysPerYear = 365;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;
  localparam int FebIndex    = 11;
  localparam int LeapDay     = 29;

  // Reciprocals: floor(x / D) == (x * ceil(2^K / D)) >> K for x < 2^(K - ceil(log2 D))
  localparam int DayDiv   = 675;
  localparam int DayShift = 42;
  localparam longint unsigned DayRecipFull =
    ((64'd1 << DayShift) + 64'(DayDiv - 1)) / 64'(DayDiv);
  localparam logic [32:0] DayRecip = 33'(DayRecipFull);

  localparam int EraShift = 40;
  localparam longint unsigned EraRecipFull =
    ((64'd1 << EraShift) + 64'(DaysPer400Y - 1)) / 64'(DaysPer400Y);
  localparam logic [22:0] EraRecip = 23'(EraRecipFull);

  localparam int HourDiv   = 225;
  localparam int HourShift = 21;
  localparam longint unsigned HourRecipFull =
    ((64'd1 << HourShift) + 64'(HourDiv - 1)) / 64'(HourDiv);
  localparam logic [13:0] HourRecip = 14'(HourRecipFull);

  localparam int MinShift = 18;
  localparam longint unsigned MinRecipFull =
    ((64'd1 << MinShift) + 64'(SecsPerMin - 1)) / 64'(SecsPerMin);
  localparam logic [12:0] MinRecip = 13'(MinRecipFull);

  localparam int QuadShift = 27;
  localparam longint unsigned QuadRecipFull =
    ((64'd1 << QuadShift) + 64'(DaysPer4Y - 1)) / 64'(DaysPer4Y);
  localparam logic [16:0] QuadRecip = 17'(QuadRecipFull);

  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } hms_t;

  // First day of each month within a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/uscal_stamp_if.sv
`default_nettype none

interface uscal_stamp_if;
  import uscal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SecsW-1:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

`default_nettype wire

### hdl/uscal_cal_if.sv
`default_nettype none

interface uscal_cal_if;
  import uscal_pkg::*;

  logic               valid;
  logic               ready;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day_of_month;
  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;
  logic [SecondW-1:0] second;
  logic               out_of_range;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output out_of_range,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input out_of_range,
                  output ready);
endinterface

`default_nettype wire

### hdl/unix_seconds_to_utc_calendar_core.sv
// Unix seconds to UTC calendar date and time.
//
// stamp (sink): one item is a signed 41-bit count of seconds since
//   1970-01-01 00:00:00 UTC. Taken when valid and ready are both high.
// calendar (source): one item per input, in order: year, month,
//   day_of_month, hour, minute, second and out_of_range. Dates outside
//   years 1..9999 raise out_of_range with every other field zero.
// Pipeline: 12 register stages (input register plus 11 arithmetic
//   stages) lie between stamp and calendar.
// Throughput: one item per cycle, sustained while calendar.ready is high.
// Stall: each stage holds while the one after it is full and stalled;
//   empty stages keep filling, so stamp stays ready until every stage
//   holds an item. A stalled result holds steady on calendar.
// Reset (rst, synchronous): empties the pipeline; calendar.valid drops
//   and stamp.ready is high in the first cycle after reset.
`default_nettype none

module unix_seconds_to_utc_calendar_core (
  input  logic               clk,
  input  logic               rst,
  uscal_stamp_if.sink        stamp,
  uscal_cal_if.source        calendar
);
  import uscal_pkg::*;

  localparam int Stages = 12;

  logic [Stages-1:0] vld;
  logic [Stages-1:0] vld_in;
  logic [Stages:0]   adv;

  always_comb begin
    adv[Stages] = calendar.ready;
    for (int i = Stages - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign vld_in      = {vld[Stages-2:0], stamp.valid};
  assign stamp.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < Stages; i++) begin
        if (adv[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // stage 0: input register
  logic signed [SecsW-1:0] secs;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      secs <= stamp.unix_seconds;
    end
  end

  // stage 1: range check, seconds since 0001-01-01
  logic [38:0] u_next;
  logic        oor_next;
  logic [38:0] s1_u;
  logic        s1_oor;

  assign oor_next = (secs < SecsMin) || (secs > SecsMax);
  assign u_next   = 39'(secs + SecsOffset);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_u   <= u_next;
      s1_oor <= oor_next;
    end
  end

  // stage 2: day count = (u >> 7) / 675
  logic [64:0] day_prod;
  logic [21:0] s2_days;
  logic [31:0] s2_u7;
  logic [6:0]  s2_low7;
  logic        s2_oor;

  assign day_prod = 65'(s1_u[38:7]) * 65'(DayRecip);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_days <= day_prod[DayShift +: 22];
      s2_u7   <= s1_u[38:7];
      s2_low7 <= s1_u[6:0];
      s2_oor  <= s1_oor;
    end
  end

  // stage 3: seconds of the day, March-based day number
  logic [31:0] rem_next;
  logic [21:0] s3_d;
  logic [16:0] s3_tod;
  logic        s3_oor;

  assign rem_next = s2_u7 - 32'(s2_days) * 32'(DayDiv);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d   <= s2_days + 22'(MarchOffset);
      s3_tod <= {rem_next[9:0], s2_low7};
      s3_oor <= s2_oor;
    end
  end

  // stage 4: 400-year eras, hour
  logic [44:0] era_prod;
  logic [26:0] hour_prod;
  logic [4:0]  s4_q400;
  logic [21:0] s4_d;
  logic [16:0] s4_tod;
  logic [4:0]  s4_hour;
  logic        s4_oor;

  assign era_prod  = 45'(s3_d) * 45'(EraRecip);
  assign hour_prod = 27'(s3_tod[16:4]) * 27'(HourRecip);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_q400 <= era_prod[EraShift +: 5];
      s4_d    <= s3_d;
      s4_tod  <= s3_tod;
      s4_hour <= hour_prod[HourShift +: 5];
      s4_oor  <= s3_oor;
    end
  end

  // stage 5: day within era, seconds within hour
  logic [4:0]  s5_q400;
  logic [17:0] s5_r400;
  logic [4:0]  s5_hour;
  logic [11:0] s5_rh;
  logic        s5_oor;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_q400 <= s4_q400;
      s5_r400 <= 18'(s4_d - 22'(s4_q400) * 22'(DaysPer400Y));
      s5_hour <= s4_hour;
      s5_rh   <= 12'(s4_tod - 17'(s4_hour) * 17'(SecsPerHour));
      s5_oor  <= s4_oor;
    end
  end

  // stage 6: centuries, minute
  logic [2:0]  c_next;
  logic [24:0] min_prod;
  logic [4:0]  s6_q400;
  logic [2:0]  s6_c;
  logic [15:0] s6_r100;
  logic [4:0]  s6_hour;
  logic [11:0] s6_rh;
  logic [5:0]  s6_minute;
  logic        s6_oor;

  assign c_next = 3'(s5_r400 >= 18'(DaysPer100Y))
                + 3'(s5_r400 >= 18'(2 * DaysPer100Y))
                + 3'(s5_r400 >= 18'(3 * DaysPer100Y))
                + 3'(s5_r400 >= 18'(4 * DaysPer100Y));
  assign min_prod = 25'(s5_rh) * 25'(MinRecip);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_q400   <= s5_q400;
      s6_c      <= c_next;
      s6_r100   <= 16'(s5_r400 - 18'(c_next) * 18'(DaysPer100Y));
      s6_hour   <= s5_hour;
      s6_rh     <= s5_rh;
      s6_minute <= min_prod[MinShift +: 6];
      s6_oor    <= s5_oor;
    end
  end

  // stage 7: 4-year cycles, second
  logic [32:0] quad_prod;
  logic [4:0]  s7_q400;
  logic [2:0]  s7_c;
  logic [4:0]  s7_f;
  logic [15:0] s7_r100;
  hms_t        s7_hms;
  logic        s7_oor;

  assign quad_prod = 33'(s6_r100) * 33'(QuadRecip);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_q400       <= s6_q400;
      s7_c          <= s6_c;
      s7_f          <= quad_prod[QuadShift +: 5];
      s7_r100       <= s6_r100;
      s7_hms.hour   <= s6_hour;
      s7_hms.minute <= s6_minute;
      s7_hms.second <= 6'(s6_rh - 12'(s6_minute) * 12'(SecsPerMin));
      s7_oor        <= s6_oor;
    end
  end

  // stage 8: day within 4-year cycle
  logic [4:0]  s8_q400;
  logic [2:0]  s8_c;
  logic [4:0]  s8_f;
  logic [10:0] s8_r4;
  hms_t        s8_hms;
  logic        s8_oor;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_q400 <= s7_q400;
      s8_c    <= s7_c;
      s8_f    <= s7_f;
      s8_r4   <= 11'(s7_r100 - 16'(s7_f) * 16'(DaysPer4Y));
      s8_hms  <= s7_hms;
      s8_oor  <= s7_oor;
    end
  end

  // stage 9: years, day within March-based year
  logic [2:0]  y_next;
  logic [13:0] s9_year;
  logic [8:0]  s9_ry;
  logic        s9_leap;
  hms_t        s9_hms;
  logic        s9_oor;

  assign y_next = 3'(s8_r4 >= 11'(DaysPerYear))
                + 3'(s8_r4 >= 11'(2 * DaysPerYear))
                + 3'(s8_r4 >= 11'(3 * DaysPerYear))
                + 3'(s8_r4 >= 11'(4 * DaysPerYear));

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s9_year <= 14'(s8_q400) * 14'd400 + 14'(s8_c) * 14'd100
               + 14'(s8_f) * 14'd4 + 14'(y_next);
      s9_ry   <= 9'(s8_r4 - 11'(y_next) * 11'(DaysPerYear));
      s9_leap <= (y_next == 3'd4) || (s8_c == 3'd4);
      s9_hms  <= s8_hms;
      s9_oor  <= s8_oor;
    end
  end

  // stage 10: month index
  logic [3:0]  mon_next;
  logic [3:0]  s10_mon;
  logic [13:0] s10_year;
  logic [8:0]  s10_ry;
  logic        s10_leap;
  hms_t        s10_hms;
  logic        s10_oor;

  always_comb begin
    mon_next = '0;
    for (int i = 1; i < 12; i++) begin
      if (s9_ry >= month_start(4'(i))) begin
        mon_next = mon_next + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      s10_mon  <= mon_next;
      s10_year <= s9_year;
      s10_ry   <= s9_ry;
      s10_leap <= s9_leap;
      s10_hms  <= s9_hms;
      s10_oor  <= s9_oor;
    end
  end

  // stage 11: day of month, leap-day corner, January/February roll
  logic [3:0]         mi;
  logic [YearW-1:0]   yr;
  logic [DayW-1:0]    dom;
  logic [YearW-1:0]   s11_year;
  logic [MonthW-1:0]  s11_month;
  logic [DayW-1:0]    s11_day;
  hms_t               s11_hms;
  logic               s11_oor;

  always_comb begin
    mi  = s10_mon;
    yr  = s10_year;
    dom = 5'(s10_ry - month_start(s10_mon) + 9'd1);
    if (s10_leap) begin
      mi  = 4'(FebIndex);
      dom = 5'(LeapDay);
      yr  = yr - 14'd1;
    end
    if (mi <= 4'd9) begin
      mi = mi + 4'd3;
    end else begin
      mi = mi - 4'd9;
      yr = yr + 14'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      s11_oor <= s10_oor;
      if (s10_oor) begin
        s11_year  <= '0;
        s11_month <= '0;
        s11_day   <= '0;
        s11_hms   <= '0;
      end else begin
        s11_year  <= yr;
        s11_month <= mi;
        s11_day   <= dom;
        s11_hms   <= s10_hms;
      end
    end
  end

  assign calendar.valid        = vld[Stages-1];
  assign calendar.year         = s11_year;
  assign calendar.month        = s11_month;
  assign calendar.day_of_month = s11_day;
  assign calendar.hour         = s11_hms.hour;
  assign calendar.minute       = s11_hms.minute;
  assign calendar.second       = s11_hms.second;
  assign calendar.out_of_range = s11_oor;

endmodule

`default_nettype wire

### hdl/uscal_checker.sv
`default_nettype none

module uscal_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [uscal_pkg::YearW-1:0]   year,
  input logic [uscal_pkg::MonthW-1:0]  month,
  input logic [uscal_pkg::DayW-1:0]    day_of_month,
  input logic [uscal_pkg::HourW-1:0]   hour,
  input logic [uscal_pkg::MinuteW-1:0] minute,
  input logic [uscal_pkg::SecondW-1:0] second,
  input logic                   out_of_range
);
  import uscal_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_item_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(year) && $stable(month) && $stable(day_of_month)
      && $stable(hour) && $stable(minute) && $stable(second) && $stable(out_of_range))
    else $error("result changed while stalled");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> year == '0 && month == '0 && day_of_month == '0
      && hour == '0 && minute == '0 && second == '0)
    else $error("out-of-range item with nonzero fields");

  a_fields_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> year >= 14'd1 && year <= 14'd9999
      && month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
      && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("calendar field out of its legal range");

endmodule

bind unix_seconds_to_utc_calendar_core uscal_checker u_uscal_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (calendar.valid),
  .out_ready    (calendar.ready),
  .year         (calendar.year),
  .month        (calendar.month),
  .day_of_month (calendar.day_of_month),
  .hour         (calendar.hour),
  .minute       (calendar.minute),
  .second       (calendar.second),
  .out_of_range (calendar.out_of_range)
);

`default_nettype wire

### tb/unix_seconds_to_utc_calendar_core_tb.sv
`timescale 1ns / 100ps

module unix_seconds_to_utc_calendar_core_tb;
  import uscal_pkg::*;

  localparam int      ClkHalf        = 6;
  localparam int      ResetCycles    = 12;
  localparam int      PhaseItems     = 400;
  localparam int      CalmItems      = 20;
  localparam int      BurstItems     = 48;
  localparam int      HoldCycles     = 96;
  localparam int      TailCycles     = 24;
  localparam int      IdleLimit      = 2000;
  localparam int      MaxPrinted     = 40;
  localparam longint  SecsPerDay     = 86400;
  localparam longint  MarchShift     = 719468;
  localparam int      NumDirected    = 23;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day_of_month;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic               out_of_range;
  } cal_t;

  typedef enum int {
    PickFull, PickSpan, PickDayEdge, PickLeapEdge, PickRangeEdge
  } pick_e;

  class calendar_scoreboard;
    cal_t                    expected_q[$];
    logic signed [SecsW-1:0] stamp_q[$];
    int                      errors;

    function new();
      errors = 0;
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) < 0) q = q - 1;
      return q;
    endfunction

    function cal_t to_calendar(logic signed [SecsW-1:0] stamp);
      longint secs, days, tod, d, q400, r400, c, r100, f, r4, y, ry, yr, mon, dom;
      cal_t   res;
      secs = stamp;
      days = floor_div(secs, SecsPerDay);
      tod  = secs - days * SecsPerDay;
      d    = days + MarchShift;
      q400 = floor_div(d, DaysPer400Y);
      r400 = d - q400 * DaysPer400Y;
      c    = r400 / DaysPer100Y;
      r100 = r400 % DaysPer100Y;
      f    = r100 / DaysPer4Y;
      r4   = r100 % DaysPer4Y;
      y    = r4 / DaysPerYear;
      ry   = r4 % DaysPerYear;
      yr   = 400 * q400 + 100 * c + 4 * f + y;
      mon  = (5 * ry + 2) / 153;
      dom  = ry - (153 * mon + 2) / 5 + 1;
      // last day of a 4-year or 400-year cycle
      if (y == 4 || c == 4) begin
        mon = FebIndex;
        dom = LeapDay;
        yr  = yr - 1;
      end
      if (mon <= 9) begin
        mon = mon + 3;
      end else begin
        mon = mon - 9;
        yr  = yr + 1;
      end
      res = '0;
      if (yr < 1 || yr > 9999) begin
        res.out_of_range = 1'b1;
      end else begin
        res.year         = yr[YearW-1:0];
        res.month        = mon[MonthW-1:0];
        res.day_of_month = dom[DayW-1:0];
        res.hour         = 5'(tod / SecsPerHour);
        res.minute       = 6'((tod % SecsPerHour) / SecsPerMin);
        res.second       = 6'(tod % SecsPerMin);
      end
      return res;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MaxPrinted) $display("mismatch: %s", what);
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    task note_stamp(logic signed [SecsW-1:0] stamp);
      expected_q.push_back(to_calendar(stamp));
      stamp_q.push_back(stamp);
    endtask

    task check_result(cal_t got);
      cal_t                    exp;
      logic signed [SecsW-1:0] stamp;
      if (expected_q.size() == 0) begin
        report($sformatf("calendar item with no stamp pending: %p", got));
        return;
      end
      exp   = expected_q.pop_front();
      stamp = stamp_q.pop_front();
      if (got.year !== exp.year)
        report($sformatf("%0d year got %0d exp %0d", stamp, got.year, exp.year));
      if (got.month !== exp.month)
        report($sformatf("%0d month got %0d exp %0d", stamp, got.month, exp.month));
      if (got.day_of_month !== exp.day_of_month)
        report($sformatf("%0d day got %0d exp %0d", stamp, got.day_of_month,
                         exp.day_of_month));
      if (got.hour !== exp.hour)
        report($sformatf("%0d hour got %0d exp %0d", stamp, got.hour, exp.hour));
      if (got.minute !== exp.minute)
        report($sformatf("%0d minute got %0d exp %0d", stamp, got.minute, exp.minute));
      if (got.second !== exp.second)
        report($sformatf("%0d second got %0d exp %0d", stamp, got.second, exp.second));
      if (got.out_of_range !== exp.out_of_range)
        report($sformatf("%0d out_of_range got %0b exp %0b", stamp, got.out_of_range,
                         exp.out_of_range));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_req = 1'b0;

  calendar_scoreboard sb;

  uscal_stamp_if stamp ();
  uscal_cal_if   calendar ();

  unix_seconds_to_utc_calendar_core u_top (
    .clk      (clk),
    .rst      (rst),
    .stamp    (stamp.sink),
    .calendar (calendar.source)
  );

  initial begin
    forever #ClkHalf clk = ~clk;
  end

  always @(posedge clk) begin
    cal_t got;
    if (!rst) begin
      if (calendar.valid && calendar.ready) begin
        got.year         = calendar.year;
        got.month        = calendar.month;
        got.day_of_month = calendar.day_of_month;
        got.hour         = calendar.hour;
        got.minute       = calendar.minute;
        got.second       = calendar.second;
        got.out_of_range = calendar.out_of_range;
        sb.check_result(got);
      end
      if (stamp.valid && stamp.ready) sb.note_stamp(stamp.unix_seconds);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int held;
    calendar.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        calendar.ready <= 1'b0;
        held = 1;
        while (held < HoldCycles) begin
          @(negedge clk);
          calendar.ready <= 1'b0;
          held++;
        end
      end else begin
        calendar.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if (rst || (stamp.valid && stamp.ready) || (calendar.valid && calendar.ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no item moved for %0d cycles", IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

  task send_stamp(logic signed [SecsW-1:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      stamp.valid <= 1'b0;
    end
    @(negedge clk);
    stamp.valid        <= 1'b1;
    stamp.unix_seconds <= secs;
    do @(posedge clk); while (!stamp.ready);
  endtask

  task wait_drained();
    @(negedge clk);
    stamp.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SecsW-1:0] random_stamp();
    logic [63:0]     w;
    longint unsigned span;
    longint          days, secs;
    pick_e           pick;
    w    = {$urandom, $urandom};
    span = longint'(SecsMax) - longint'(SecsMin) + 1;
    pick = pick_e'($urandom_range(9) < 2 ? PickFull :
                   $urandom_range(9) < 6 ? PickSpan : $urandom_range(2) + 2);
    case (pick)
      PickFull: return w[SecsW-1:0];
      PickSpan: begin
        secs = longint'(SecsMin) + longint'(w % span);
      end
      PickDayEdge: begin
        days = longint'(SecsMin) / SecsPerDay + longint'(w % (span / SecsPerDay));
        secs = days * SecsPerDay + ($urandom_range(1) ? $urandom_range(3)
                                                      : SecsPerDay - 1 - $urandom_range(3));
      end
      PickLeapEdge: begin
        // ends and starts of 4-year and 400-year cycles in the March-based count
        days = longint'($urandom_range(24)) * DaysPer400Y
             + longint'($urandom_range(3)) * DaysPer100Y
             + longint'($urandom_range(24)) * DaysPer4Y - MarchShift;
        case ($urandom_range(3))
          0:       days += DaysPer4Y - 1;
          1:       days += DaysPer4Y - 2;
          2:       days += 0;
          default: days = days - days % 1 + (DaysPer400Y - 1)
                          - longint'($urandom_range(3)) * DaysPer100Y;
        endcase
        secs = days * SecsPerDay + longint'($urandom_range(SecsPerDay - 1));
      end
      default: begin
        secs = ($urandom_range(1) ? longint'(SecsMin) : longint'(SecsMax))
             + longint'($urandom_range(200000)) - 100000;
      end
    endcase
    return secs[SecsW-1:0];
  endfunction

  initial begin : main
    longint dir_secs [NumDirected] = '{
      0, -1, 86399, 86400, -86400, -86401,
      2147483647, 2147483648,
      -62135596800, -62135596801, 253402300799, 253402300800,
      1099511627775, -1099511627776,
      951827696, 951868800, 951868799, 1078012800,
      -2203891200, -2203891201, 13574563200, -13564368000,
      1078099199
    };
    int phase, i;

    sb = new();
    stamp.valid        = 1'b0;
    stamp.unix_seconds = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < NumDirected; i++) send_stamp(dir_secs[i][SecsW-1:0]);
    wait_drained();

    // long receiver hold-off while the sender keeps offering items
    hold_req = 1'b1;
    for (i = 0; i < BurstItems; i++) send_stamp(random_stamp());
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      for (i = 0; i < PhaseItems; i++) begin
        if (i % 100 < CalmItems) begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end else begin
          case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
          endcase
        end
        send_stamp(random_stamp());
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d calendar items never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
